// ===== rtl/assert_macros.svh =====
// Assertion macros for the squeeze decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/hrle_pkg.sv =====
// Shared types and constants of the squeeze decoder.
`timescale 1ns / 1ps
package hrle_pkg;

    localparam logic       OP_LOAD    = 1'b0;
    localparam logic       OP_DECODE  = 1'b1;
    localparam logic [7:0] ESC_BYTE   = 8'h90;
    localparam logic [7:0] CTRLZ_BYTE = 8'h1A;
    localparam logic [8:0] END_SYM    = 9'd256;
    localparam logic signed [9:0] END_CHILD = -10'sd257;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic signed [9:0] left_child;
        logic signed [9:0] right_child;
    } t_tree_node;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] run_length;
        logic       end_of_stream;
        logic       last;
    } t_result;

endpackage

// ===== rtl/hrle_if.sv =====
// Item channels of the squeeze decoder: input items and result items.
`timescale 1ns / 1ps
interface hrle_in_if;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [7:0]        node_index;
    logic signed [9:0] left_child;
    logic signed [9:0] right_child;
    logic [7:0]        data_byte;

    modport source (output valid, opcode, node_index, left_child, right_child, data_byte,
                    input ready);
    modport sink   (input valid, opcode, node_index, left_child, right_child, data_byte,
                    output ready);
endinterface

interface hrle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [7:0] run_length;
    logic       end_of_stream;
    logic       last;

    modport source (output valid, out_byte, run_length, end_of_stream, last, input ready);
    modport sink   (input valid, out_byte, run_length, end_of_stream, last, output ready);
endinterface

// ===== rtl/hrle_tree_ram.sv =====
// Decoding-tree node memory with registered read and a reset value for the root node.
`timescale 1ns / 1ps
module hrle_tree_ram #(
    parameter int TREE_NODES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [$clog2(TREE_NODES)-1:0] i_wr_addr,
    input  hrle_pkg::t_tree_node          i_wr_node,
    input  logic                          i_rd_en,
    input  logic [$clog2(TREE_NODES)-1:0] i_rd_addr,
    output hrle_pkg::t_tree_node          o_rd_node
);

    localparam int AW = $clog2(TREE_NODES);

    hrle_pkg::t_tree_node r_mem [TREE_NODES];
    hrle_pkg::t_tree_node r_rd_node;
    logic                 r_node0_wr;
    logic                 r_rd_dflt;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_node;
        end
        if (i_rd_en) begin
            r_rd_node <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node0_wr <= 1'b0;
            r_rd_dflt  <= 1'b0;
        end else begin
            if (i_wr_en && (i_wr_addr == AW'(0))) begin
                r_node0_wr <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_dflt <= (i_rd_addr == AW'(0)) && !r_node0_wr;
            end
        end
    end

    always_comb begin
        if (r_rd_dflt) begin
            o_rd_node.left_child  = hrle_pkg::END_CHILD;
            o_rd_node.right_child = hrle_pkg::END_CHILD;
        end else begin
            o_rd_node = r_rd_node;
        end
    end

endmodule

// ===== rtl/huffman_rle90_unsqueeze.sv =====
// Top level of the squeeze decoder: tree walk sequencer, run-length stage and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A load item writes one tree node; the block stays ready. A decode item is accepted in idle,
// which reads the current node; the walk then takes up to eight of its bits through the node
// memory at one read per bit (fewer when the stream ends inside the byte), and the flush hands
// over its final result. A step waits while a result finds both the holding register and the
// output register full. Decode items after the end of the stream start no walk and give
// nothing. Results carry run lengths rather than repeated bytes; one result waits in a holding
// register beside the output register while the walk carries on. No clearing pass follows reset.
module huffman_rle90_unsqueeze #(
    parameter int TREE_NODES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hrle_in_if.sink           i_in,
    hrle_out_if.source        o_out
);

    localparam int          AW      = $clog2(TREE_NODES);
    localparam logic [10:0] NODES_W = 11'(TREE_NODES);

    hrle_pkg::t_state     r_state, n_state;
    logic [AW-1:0]        r_pos;
    logic                 r_esc;
    logic [7:0]           r_prev;
    logic                 r_done;
    logic [7:0]           r_bits;
    logic [2:0]           r_bit_cnt;
    logic                 r_pend_vld;
    hrle_pkg::t_result    r_pend;
    logic                 r_out_vld;
    hrle_pkg::t_result    r_out;

    hrle_pkg::t_tree_node rd_node;
    hrle_pkg::t_tree_node wr_node;
    logic                 wr_en;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;

    logic                 accept;
    logic                 out_free;
    logic signed [9:0]    child;
    logic                 is_node;
    logic [8:0]           leaf_val;
    logic [8:0]           sym;
    logic [AW-1:0]        next_pos;
    logic                 has_res;
    hrle_pkg::t_result    res;
    logic                 n_esc;
    logic [7:0]           n_prev;
    logic                 n_done;
    logic                 stall;
    logic                 advance;
    logic                 push;
    logic                 push_last;
    logic                 walk_end;

    hrle_tree_ram #(
        .TREE_NODES (TREE_NODES)
    ) u_tree (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_in.node_index)),
        .i_wr_node (wr_node),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_node (rd_node)
    );

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;
    assign wr_node  = '{left_child: i_in.left_child, right_child: i_in.right_child};
    assign wr_en    = accept && (i_in.opcode == hrle_pkg::OP_LOAD)
                      && ({3'b000, i_in.node_index} < NODES_W);

    // tree step for the current bit
    always_comb begin
        child    = r_bits[r_bit_cnt] ? rd_node.right_child : rd_node.left_child;
        is_node  = !child[9] && ({2'b00, child[8:0]} < NODES_W);
        next_pos = is_node ? AW'(child[8:0]) : '0;
        leaf_val = ~child[8:0];
        if (!child[9] || (leaf_val > hrle_pkg::END_SYM)) begin
            sym = hrle_pkg::END_SYM;
        end else begin
            sym = leaf_val;
        end
    end

    // run-length stage
    always_comb begin
        has_res = 1'b0;
        res     = '0;
        n_esc   = r_esc;
        n_prev  = r_prev;
        n_done  = r_done;
        if (!is_node) begin
            priority if (sym == hrle_pkg::END_SYM) begin
                n_esc              = 1'b0;
                n_done             = 1'b1;
                has_res            = 1'b1;
                res.end_of_stream  = 1'b1;
            end else if (r_esc) begin
                n_esc   = 1'b0;
                has_res = 1'b1;
                if (sym == 9'd0) begin
                    res.out_byte   = hrle_pkg::ESC_BYTE;
                    res.run_length = 8'd1;
                end else begin
                    res.out_byte   = r_prev;
                    res.run_length = (sym > 9'd1) ? 8'(sym - 9'd1) : 8'd1;
                end
            end else if (sym[7:0] == hrle_pkg::ESC_BYTE) begin
                n_esc = 1'b1;
            end else if (sym[7:0] == hrle_pkg::CTRLZ_BYTE) begin
                n_done            = 1'b1;
                has_res           = 1'b1;
                res.end_of_stream = 1'b1;
            end else begin
                n_prev         = sym[7:0];
                has_res        = 1'b1;
                res.out_byte   = sym[7:0];
                res.run_length = 8'd1;
            end
        end
    end

    assign stall    = has_res && r_pend_vld && !out_free;
    assign walk_end = (r_bit_cnt == 3'd7) || n_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hrle_pkg::S_IDLE: begin
                if (accept && (i_in.opcode == hrle_pkg::OP_DECODE) && !r_done) begin
                    n_state = hrle_pkg::S_WALK;
                end
            end
            hrle_pkg::S_WALK: begin
                if (!stall && walk_end) begin
                    n_state = hrle_pkg::S_FLUSH;
                end
            end
            hrle_pkg::S_FLUSH: begin
                if (!r_pend_vld || out_free) begin
                    n_state = hrle_pkg::S_IDLE;
                end
            end
            default: n_state = hrle_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        advance    = 1'b0;
        push       = 1'b0;
        push_last  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_pos;
        unique case (r_state)
            hrle_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                rd_en      = accept && (i_in.opcode == hrle_pkg::OP_DECODE);
            end
            hrle_pkg::S_WALK: begin
                advance = !stall;
                push    = !stall && has_res && r_pend_vld;
                rd_en   = !stall;
                rd_addr = next_pos;
            end
            hrle_pkg::S_FLUSH: begin
                push      = r_pend_vld && out_free;
                push_last = 1'b1;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= hrle_pkg::S_IDLE;
            r_pos      <= '0;
            r_esc      <= 1'b0;
            r_prev     <= 8'd0;
            r_done     <= 1'b0;
            r_bit_cnt  <= 3'd0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hrle_pkg::S_IDLE) begin
                r_bit_cnt <= 3'd0;
            end
            if (advance) begin
                r_pos     <= next_pos;
                r_esc     <= n_esc;
                r_prev    <= n_prev;
                r_done    <= n_done;
                r_bit_cnt <= r_bit_cnt + 3'd1;
                if (has_res) begin
                    r_pend_vld <= 1'b1;
                end
            end
            if ((r_state == hrle_pkg::S_FLUSH) && push) begin
                r_pend_vld <= 1'b0;
            end
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bits <= i_in.data_byte;
        end
        if (advance && has_res) begin
            r_pend <= res;
        end
        if (push) begin
            r_out <= '{out_byte:      r_pend.out_byte,
                       run_length:    r_pend.run_length,
                       end_of_stream: r_pend.end_of_stream,
                       last:          push_last};
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.out_byte      = r_out.out_byte;
    assign o_out.run_length    = r_out.run_length;
    assign o_out.end_of_stream = r_out.end_of_stream;
    assign o_out.last          = r_out.last;

    `ASSERT_IMPLIES(a_ready_no_pend, i_clk, i_rst_n, i_in.ready, !r_pend_vld, "item taken with result pending")
    `ASSERT_IMPLIES(a_eos_is_last, i_clk, i_rst_n, r_out_vld && r_out.end_of_stream, r_out.last, "end result not last")
    `ASSERT_HOLDS(a_done_no_esc, i_clk, i_rst_n, !(r_done && r_esc), "escape pending after end")

endmodule
